/* hdl/quaternion_to_euler_angles_top_assert.svh */
// Assertion macros used by the checker file.
`ifndef QUATERNION_TO_EULER_ANGLES_TOP_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define QTE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define QTE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/qte_pkg.sv */
package qte_pkg;

  localparam int PRW   = 34;  // floored Q.30 product
  localparam int OPW   = 38;  // atan2 operand
  localparam int ANG_W = 35;  // Q.30 angle
  localparam int C2_W  = 62;  // square root datapath
  localparam int SQRT_STEPS = 31;
  localparam int CORDIC_FIXED_LAT = 7; // prescale stage + six shift stages

  localparam logic signed [ANG_W-1:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [31:0] LOCK_ROLL_Q28  = 32'sd843314857;
  localparam logic signed [31:0] LOCK_PITCH_Q28 = 32'sd421657428;

  typedef enum logic [1:0] {
    LOCK_NONE = 2'd0,
    LOCK_POS  = 2'd1,
    LOCK_NEG  = 2'd2
  } lock_t;

  function automatic logic [31:0] atan_q30(int i);
    logic [31:0] r;
    case (i)
      0:  r = 32'd843314857;
      1:  r = 32'd497837829;
      2:  r = 32'd263043837;
      3:  r = 32'd133525159;
      4:  r = 32'd67021687;
      5:  r = 32'd33543516;
      6:  r = 32'd16775851;
      7:  r = 32'd8388437;
      8:  r = 32'd4194283;
      9:  r = 32'd2097149;
      default: r = 32'd1 << (30 - i);
    endcase
    return r;
  endfunction

endpackage

/* hdl/qte_if.sv */
interface qte_quat_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] qw;
  logic signed [31:0] qx;
  logic signed [31:0] qy;
  logic signed [31:0] qz;
  modport source (output valid, output qw, output qx, output qy, output qz, input ready);
  modport sink   (input valid, input qw, input qx, input qy, input qz, output ready);
endinterface

interface qte_angles_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] roll;
  logic signed [31:0] pitch;
  logic signed [31:0] yaw;
  logic [1:0]         lock_case;
  modport source (output valid, output roll, output pitch, output yaw, output lock_case,
                  input ready);
  modport sink   (input valid, input roll, input pitch, input yaw, input lock_case,
                  output ready);
endinterface

interface qte_cfg_if;
  logic       valid;
  logic       ready;
  logic [9:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/qte_cordic.sv */
module qte_cordic #(
  parameter int STEPS = 28
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [qte_pkg::OPW-1:0]     y_in,
  input  logic signed [qte_pkg::OPW-1:0]     x_in,
  output logic signed [qte_pkg::ANG_W-1:0]   angle
);
  import qte_pkg::*;

  localparam int XW  = 62;
  localparam int MW  = 59;
  localparam int NORM_N = CORDIC_FIXED_LAT - 1;
  localparam int LAT = CORDIC_FIXED_LAT + STEPS;

  typedef struct packed {
    logic                    zero;
    logic signed [XW-1:0]    x;
    logic signed [XW-1:0]    y;
    logic signed [ANG_W-1:0] z;
    logic [MW-1:0]           m;
  } cst_t;

  cst_t st [0:LAT-1];
  cst_t pre;

  logic signed [XW-1:0] xe, ye, xn, yn, ya;

  // fold left half plane onto the right, magnitude for scaling
  always_comb begin
    xe = XW'(x_in);
    ye = XW'(y_in);
    pre.zero = (x_in == '0) && (y_in == '0);
    if (x_in < 0) begin
      xn = -xe;
      yn = -ye;
      pre.z = (y_in >= 0) ? PI_Q30 : -PI_Q30;
    end else begin
      xn = xe;
      yn = ye;
      pre.z = '0;
    end
    ya = yn[XW-1] ? -yn : yn;
    pre.x = xn;
    pre.y = yn;
    pre.m = (xn > ya) ? MW'(xn) : MW'(ya);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= pre;
    end
  end

  // binary-search normalisation: bit 58 becomes the top set bit
  for (genvar k = 0; k < NORM_N; k++) begin : g_norm
    localparam int SH = 32 >> k;
    always_ff @(posedge clk) begin
      if (en) begin
        st[k+1].zero <= st[k].zero;
        st[k+1].z    <= st[k].z;
        if (st[k].m < (MW'(1) << (MW - SH))) begin
          st[k+1].m <= st[k].m << SH;
          st[k+1].x <= st[k].x <<< SH;
          st[k+1].y <= st[k].y <<< SH;
        end else begin
          st[k+1].m <= st[k].m;
          st[k+1].x <= st[k].x;
          st[k+1].y <= st[k].y;
        end
      end
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_iter
    localparam int S = NORM_N + 1 + i;
    logic signed [XW-1:0] xs, ys;
    logic signed [ANG_W-1:0] at;
    assign xs = st[S-1].x >>> i;
    assign ys = st[S-1].y >>> i;
    assign at = $signed(ANG_W'(atan_q30(i)));
    always_ff @(posedge clk) begin
      if (en) begin
        st[S].zero <= st[S-1].zero;
        st[S].m    <= st[S-1].m;
        if (!st[S-1].y[XW-1]) begin
          st[S].x <= st[S-1].x + ys;
          st[S].y <= st[S-1].y - xs;
          st[S].z <= st[S-1].z + at;
        end else begin
          st[S].x <= st[S-1].x - ys;
          st[S].y <= st[S-1].y + xs;
          st[S].z <= st[S-1].z - at;
        end
      end
    end
  end

  assign angle = st[LAT-1].zero ? '0 : st[LAT-1].z;

endmodule

/* hdl/quaternion_to_euler_angles_top.sv */
// Quaternion (w,x,y,z, signed Q2.30, not normalised) to ZYX roll/pitch/yaw in signed Q4.28
// radians. Fully pipelined: one word is taken every cycle unless the result side stalls;
// each result passes through the product, lock test, cos^2 square, 31 square root and
// 7 + CORDIC_STEPS CORDIC stages and the output register. The whole pipe advances
// whenever the output register is empty or being taken, so a stall on the result side
// holds every word in place and nothing is dropped or repeated. Near t = +1 or -1, within
// lock_tolerance LSBs, lock_case flags gimbal lock and roll/pitch become constants.
// lock_tolerance is written through cfg (always ready) and resets to 2.
module quaternion_to_euler_angles_top #(
  parameter int CORDIC_STEPS = 28
) (
  input logic              clk,
  input logic              rst,
  qte_cfg_if.sink          cfg,
  qte_quat_if.sink         quat,
  qte_angles_if.source     angles
);
  import qte_pkg::*;

  localparam int CLAT = CORDIC_STEPS + CORDIC_FIXED_LAT;

  typedef struct packed {
    logic signed [PRW-1:0] zx, wy, xy, wz, xz, wx, yz, xx, yy, zz;
  } prod_t;

  typedef struct packed {
    lock_t               lock;
    logic signed [31:0]  s;
    logic signed [OPW-1:0] ay, ax, by, bx;
  } opnd_t;

  typedef struct packed {
    logic [C2_W-1:0] rem;
    logic [C2_W-1:0] res;
    opnd_t           op;
  } sqst_t;

  logic en;
  logic [9:0] tol;

  // pipe advances when the output register can take a word
  assign en         = !angles.valid || angles.ready;
  assign quat.ready = en;
  assign cfg.ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= 10'd2;
    end else if (cfg.valid) begin
      tol <= cfg.data;
    end
  end

  // ---- stage 1: the ten component products, floored to Q.30
  logic signed [63:0] m_zx, m_wy, m_xy, m_wz, m_xz, m_wx, m_yz, m_xx, m_yy, m_zz;
  prod_t p1;
  logic  v1;

  assign m_zx = quat.qz * quat.qx;
  assign m_wy = quat.qw * quat.qy;
  assign m_xy = quat.qx * quat.qy;
  assign m_wz = quat.qw * quat.qz;
  assign m_xz = quat.qx * quat.qz;
  assign m_wx = quat.qw * quat.qx;
  assign m_yz = quat.qy * quat.qz;
  assign m_xx = quat.qx * quat.qx;
  assign m_yy = quat.qy * quat.qy;
  assign m_zz = quat.qz * quat.qz;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= quat.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1.zx <= m_zx[63:30];
      p1.wy <= m_wy[63:30];
      p1.xy <= m_xy[63:30];
      p1.wz <= m_wz[63:30];
      p1.xz <= m_xz[63:30];
      p1.wx <= m_wx[63:30];
      p1.yz <= m_yz[63:30];
      p1.xx <= m_xx[63:30];
      p1.yy <= m_yy[63:30];
      p1.zz <= m_zz[63:30];
    end
  end

  // ---- stage 2: t, saturation, lock test, atan2 operands
  logic signed [PRW+1:0] t_raw;
  logic signed [31:0]    t;
  logic signed [32:0]    t33, tol33;
  opnd_t                 op2_next, op2;
  logic                  v2;

  always_comb begin
    t_raw = (36'(p1.zx) - 36'(p1.wy)) <<< 1;
    if (t_raw > 36'sd1073741824) begin
      t = 32'sd1073741824;
    end else if (t_raw < -36'sd1073741824) begin
      t = -32'sd1073741824;
    end else begin
      t = 32'(t_raw);
    end
    t33   = 33'(t);
    tol33 = $signed({23'd0, tol});
    if (t33 >= 33'sd1073741824 - tol33) begin
      op2_next.lock = LOCK_POS;
    end else if (t33 <= -33'sd1073741824 + tol33) begin
      op2_next.lock = LOCK_NEG;
    end else begin
      op2_next.lock = LOCK_NONE;
    end
    op2_next.s = -t;
    if (op2_next.lock != LOCK_NONE) begin
      // single yaw term: atan2(xy - wz, xz + wy)
      op2_next.ay = OPW'(p1.xy) - OPW'(p1.wz);
      op2_next.ax = OPW'(p1.xz) + OPW'(p1.wy);
    end else begin
      op2_next.ay = (OPW'(p1.wx) + OPW'(p1.yz)) <<< 1;
      op2_next.ax = 38'sd1073741824 - ((OPW'(p1.xx) + OPW'(p1.yy)) <<< 1);
    end
    op2_next.by = (OPW'(p1.wz) + OPW'(p1.xy)) <<< 1;
    op2_next.bx = 38'sd1073741824 - ((OPW'(p1.yy) + OPW'(p1.zz)) <<< 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op2 <= op2_next;
    end
  end

  // ---- stage 3: cos^2 = 1 - s^2, start of the square root
  logic signed [63:0] s_sq;
  sqst_t sq [0:SQRT_STEPS];
  logic  sqv [0:SQRT_STEPS];

  assign s_sq = op2.s * op2.s;

  always_ff @(posedge clk) begin
    if (rst) begin
      sqv[0] <= 1'b0;
    end else if (en) begin
      sqv[0] <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq[0].rem <= (C2_W'(1) << 60) - C2_W'(s_sq);
      sq[0].res <= '0;
      sq[0].op  <= op2;
    end
  end

  // ---- square root, one result bit per stage
  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    logic [C2_W-1:0] bitv, trial;
    assign bitv  = C2_W'(1) << (60 - 2 * j);
    assign trial = sq[j].res + bitv;

    always_ff @(posedge clk) begin
      if (rst) begin
        sqv[j+1] <= 1'b0;
      end else if (en) begin
        sqv[j+1] <= sqv[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq[j+1].op <= sq[j].op;
        if (sq[j].rem >= trial) begin
          sq[j+1].rem <= sq[j].rem - trial;
          sq[j+1].res <= (sq[j].res >> 1) + bitv;
        end else begin
          sq[j+1].rem <= sq[j].rem;
          sq[j+1].res <= sq[j].res >> 1;
        end
      end
    end
  end

  // ---- three CORDIC vectoring pipes: roll (or lock yaw), yaw, pitch
  opnd_t                   opc;
  logic signed [OPW-1:0]   cy, cx;
  logic signed [ANG_W-1:0] ang_a, ang_b, ang_c;

  assign opc = sq[SQRT_STEPS].op;
  assign cy  = OPW'(opc.s);
  assign cx  = $signed({1'b0, sq[SQRT_STEPS].res[OPW-2:0]});

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_a (
    .clk(clk), .en(en), .y_in(opc.ay), .x_in(opc.ax), .angle(ang_a));
  qte_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_b (
    .clk(clk), .en(en), .y_in(opc.by), .x_in(opc.bx), .angle(ang_b));
  qte_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_c (
    .clk(clk), .en(en), .y_in(cy), .x_in(cx), .angle(ang_c));

  // valid and lock code ride alongside the CORDIC pipes
  logic  dv [0:CLAT-1];
  lock_t dl [0:CLAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= sqv[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dl[0] <= opc.lock;
    end
  end

  for (genvar d = 1; d < CLAT; d++) begin : g_dly
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[d] <= 1'b0;
      end else if (en) begin
        dv[d] <= dv[d-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dl[d] <= dl[d-1];
      end
    end
  end

  // ---- output stage: branch select and round half up to Q4.28
  function automatic logic [31:0] to_q28(logic signed [ANG_W-1:0] v);
    logic signed [ANG_W:0] r;
    r = (ANG_W+1)'(v) + 36'sd2;
    return r[33:2];
  endfunction

  lock_t                   lk;
  logic signed [ANG_W-1:0] roll_q30, pitch_q30, yaw_q30;

  assign lk = dl[CLAT-1];

  always_comb begin
    unique case (lk)
      LOCK_POS: begin
        roll_q30  = PI_Q30;
        pitch_q30 = -HALF_PI_Q30;
        yaw_q30   = ang_a - PI_Q30;
      end
      LOCK_NEG: begin
        roll_q30  = PI_Q30;
        pitch_q30 = HALF_PI_Q30;
        yaw_q30   = PI_Q30 - ang_a;
      end
      default: begin
        roll_q30  = ang_a;
        pitch_q30 = ang_c;
        yaw_q30   = ang_b;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      angles.valid <= 1'b0;
    end else if (en) begin
      angles.valid <= dv[CLAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angles.roll      <= to_q28(roll_q30);
      angles.pitch     <= to_q28(pitch_q30);
      angles.yaw       <= to_q28(yaw_q30);
      angles.lock_case <= 2'(lk);
    end
  end

endmodule

/* hdl/qte_chk.sv */
`include "quaternion_to_euler_angles_top_assert.svh"

module qte_chk (
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [31:0] roll,
  input logic signed [31:0] pitch,
  input logic [1:0]        lock_case,
  input logic              cfg_ready
);
  import qte_pkg::*;

  `QTE_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(roll), "result word dropped or changed while stalled")
  `QTE_ASSERT_NOW(a_ready_free, !out_valid || out_ready, in_ready, "input stalled with free output")
  `QTE_ASSERT_NOW(a_lock_roll, out_valid && lock_case != LOCK_NONE, roll == LOCK_ROLL_Q28, "lock roll is not pi")
  `QTE_ASSERT_NOW(a_lock_pitch, out_valid && lock_case == LOCK_POS, pitch == -LOCK_PITCH_Q28, "lock pitch wrong")
  `QTE_ASSERT_NOW(a_cfg_rdy, 1'b1, cfg_ready, "cfg not ready")

endmodule

bind quaternion_to_euler_angles_top qte_chk u_qte_chk (
  .clk(clk), .rst(rst), .in_ready(quat.ready), .out_valid(angles.valid),
  .out_ready(angles.ready), .roll(angles.roll), .pitch(angles.pitch),
  .lock_case(angles.lock_case), .cfg_ready(cfg.ready));
